[hw/rtl/congruence_signature_table_top_macros.svh]
// assertion macros used by the signature table rtl
`ifndef CONGRUENCE_SIGNATURE_TABLE_TOP_MACROS_SVH
`define CONGRUENCE_SIGNATURE_TABLE_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS
`define CST_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define CST_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);
`else
`define CST_ASSERT(lbl, prop, msg)
`define CST_ASSERT_NEVER(lbl, prop, msg)
`endif

`endif

[hw/rtl/cst_pkg.sv]
package cst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned ID_BITS_DEF       = 16;
  localparam int unsigned TERM_BITS         = 16;

  localparam logic [1:0] CMD_ENTER  = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK          = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND   = 2'd1;
  localparam logic [1:0] ST_WRONG_ARITY = 2'd2;
  localparam logic [1:0] ST_FULL        = 2'd3;

  localparam logic [2:0] ARITY_ONE = 3'd1;
  localparam logic [2:0] ARITY_TWO = 3'd2;

  typedef struct packed {
    logic [1:0]  command;
    logic [2:0]  term_arity;
    logic [15:0] symbol_id;
    logic [15:0] first_class;
    logic [15:0] second_class;
    logic [15:0] term_ref;
  } cst_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] found_term;
  } cst_out_t;

endpackage

[hw/rtl/cst_stream_if.sv]
interface cst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[hw/rtl/cst_ram.sv]
module cst_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[hw/rtl/congruence_signature_table_top.sv]
// Signature table for congruence closure.
// in_i carries one command per transfer: enter, remove or query of a key made
// of the arity, the function symbol and the already resolved argument classes.
// out_o returns one result per command: a status and, for a query hit, the
// stored term.
// Each valid command scans every slot through one read port of the table RAM
// and one key comparator, then waits in the finish state until the output
// register is free; the next command is taken once its result is loaded.
// Commands with a wrong arity or the unused code skip the scan and go
// straight to the finish state.
// in_i.ready is high only while no command is in work.
// After reset the block clears the table, one slot a cycle, and takes no
// command meanwhile.
// The result sits in an output register: a stalled receiver does not block
// the next command, but a finished command waits until the register is free.
module congruence_signature_table_top #(
  parameter int unsigned TABLE_ENTRIES = cst_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned ID_BITS       = cst_pkg::ID_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cst_stream_if.sink   in_i,
  cst_stream_if.source out_o
);
  import cst_pkg::*;
  `include "congruence_signature_table_top_macros.svh"

  localparam int unsigned AW = $clog2(TABLE_ENTRIES);
  localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned KW = 1 + 3 * ID_BITS;
  localparam int unsigned RW = 1 + KW + TERM_BITS;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  function automatic logic [ID_BITS-1:0] id_fit(logic [15:0] v);
    logic [31:0] w;
    w = {16'b0, v};
    return w[ID_BITS-1:0];
  endfunction

  state_e state_q, state_d;
  logic [CW-1:0] ctr_q, ctr_d;
  logic          rd_pend_q, rd_pend_d;
  logic [AW-1:0] rd_idx_q, rd_idx_d;
  logic          hit_q, hit_d;
  logic          free_q, free_d;
  logic [AW-1:0] hit_idx_q, hit_idx_d;
  logic [AW-1:0] free_idx_q, free_idx_d;
  logic [TERM_BITS-1:0] hit_term_q, hit_term_d;
  logic [1:0]    cmd_q;
  logic [2:0]    arity_q;
  logic [KW-1:0] key_q;
  logic [TERM_BITS-1:0] term_q;
  logic          out_valid_q, out_valid_d;
  cst_out_t      out_q, out_d;

  logic          in_fire, issue, finish, arity_ok;
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [RW-1:0] ram_wdata, ram_rdata;
  logic          rd_valid;
  logic [KW-1:0] rd_key;
  logic [TERM_BITS-1:0] rd_term;
  logic          two_args;
  logic [KW-1:0] in_key;

  cst_ram #(.WIDTH(RW), .DEPTH(TABLE_ENTRIES)) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign rd_valid = ram_rdata[RW-1];
  assign rd_key   = ram_rdata[TERM_BITS +: KW];
  assign rd_term  = ram_rdata[TERM_BITS-1:0];

  assign in_i.ready  = (state_q == S_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_o.valid   = out_valid_q;
  assign out_o.payload = out_q;

  assign two_args = (in_i.payload.term_arity == ARITY_TWO);
  assign in_key = {two_args, id_fit(in_i.payload.symbol_id), id_fit(in_i.payload.first_class),
                   two_args ? id_fit(in_i.payload.second_class) : {ID_BITS{1'b0}}};

  assign arity_ok = (arity_q == ARITY_ONE) || (arity_q == ARITY_TWO);
  assign issue    = (state_q == S_SCAN) && (ctr_q < CW'(TABLE_ENTRIES));
  assign finish   = (state_q == S_DONE) && (!out_valid_q || out_o.ready);
  assign ram_raddr = ctr_q[AW-1:0];

  // status and table update of the finishing command, and the table clear after reset
  always_comb begin
    out_d     = '0;
    ram_we    = 1'b0;
    ram_waddr = ctr_q[AW-1:0];
    ram_wdata = '0;
    if (state_q == S_CLEAR) begin
      ram_we = 1'b1;
    end else if (!(cmd_q == CMD_ENTER || cmd_q == CMD_REMOVE || cmd_q == CMD_QUERY)) begin
      out_d.status = ST_OK;
    end else if (!arity_ok) begin
      out_d.status = ST_WRONG_ARITY;
    end else begin
      unique case (cmd_q)
        CMD_ENTER: begin
          if (!hit_q && !free_q) begin
            out_d.status = ST_FULL;
          end else begin
            out_d.status = ST_OK;
          end
          ram_we    = finish && !hit_q && free_q;
          ram_waddr = free_idx_q;
          ram_wdata = {1'b1, key_q, term_q};
        end
        CMD_REMOVE: begin
          out_d.status = hit_q ? ST_OK : ST_NOT_FOUND;
          ram_we    = finish && hit_q;
          ram_waddr = hit_idx_q;
          ram_wdata = {1'b0, key_q, term_q};
        end
        CMD_QUERY: begin
          out_d.status     = hit_q ? ST_OK : ST_NOT_FOUND;
          out_d.found_term = hit_q ? hit_term_q : '0;
        end
        default: begin
          out_d.status = ST_OK;
        end
      endcase
    end
  end

  always_comb begin
    state_d    = state_q;
    ctr_d      = ctr_q;
    rd_pend_d  = issue;
    rd_idx_d   = ctr_q[AW-1:0];
    hit_d      = hit_q;
    free_d     = free_q;
    hit_idx_d  = hit_idx_q;
    free_idx_d = free_idx_q;
    hit_term_d = hit_term_q;
    out_valid_d = out_valid_q;
    if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_CLEAR: begin
        ctr_d = ctr_q + CW'(1);
        if (ctr_q[AW-1:0] == AW'(TABLE_ENTRIES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        ctr_d  = '0;
        hit_d  = 1'b0;
        free_d = 1'b0;
        if (in_fire) begin
          if ((in_i.payload.command == CMD_ENTER || in_i.payload.command == CMD_REMOVE ||
               in_i.payload.command == CMD_QUERY) &&
              (in_i.payload.term_arity == ARITY_ONE || two_args)) begin
            state_d = S_SCAN;
          end else begin
            state_d = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (issue) begin
          ctr_d = ctr_q + CW'(1);
        end
        if (rd_pend_q) begin
          if (rd_valid && (rd_key == key_q) && !hit_q) begin
            hit_d      = 1'b1;
            hit_idx_d  = rd_idx_q;
            hit_term_d = rd_term;
          end
          if (!rd_valid && !free_q) begin
            free_d     = 1'b1;
            free_idx_d = rd_idx_q;
          end
        end
        if (!issue) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        if (finish) begin
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      ctr_q       <= '0;
      rd_pend_q   <= 1'b0;
      hit_q       <= 1'b0;
      free_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ctr_q       <= ctr_d;
      rd_pend_q   <= rd_pend_d;
      hit_q       <= hit_d;
      free_q      <= free_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    free_idx_q <= free_idx_d;
    hit_term_q <= hit_term_d;
    if (in_fire) begin
      cmd_q   <= in_i.payload.command;
      arity_q <= in_i.payload.term_arity;
      key_q   <= in_key;
      term_q  <= in_i.payload.term_ref;
    end
    if (finish) begin
      out_q <= out_d;
    end
  end

  `CST_ASSERT(a_found_only_on_ok, out_valid_q |-> (out_q.status == ST_OK || out_q.found_term == '0), "found term without ok status")
  `CST_ASSERT_NEVER(a_no_write_in_scan, (state_q == S_SCAN) && ram_we, "table write during scan")
  `CST_ASSERT(a_ctr_bound, (state_q == S_SCAN) |-> (ctr_q <= CW'(TABLE_ENTRIES)), "scan counter overrun")
  `CST_ASSERT(a_result_loaded, finish |=> out_valid_q, "finished command left no result")
endmodule

[verif/testbench.sv]
localparam logic [1:0] CMD_UNUSED = 2'd3;

class sig_table_scoreboard;
  localparam int unsigned SLOTS = cst_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned ID_W  = cst_pkg::ID_BITS_DEF;

  bit                slot_used   [SLOTS];
  bit                slot_two    [SLOTS];
  logic [15:0]       slot_sym    [SLOTS];
  logic [15:0]       slot_first  [SLOTS];
  logic [15:0]       slot_second [SLOTS];
  logic [15:0]       slot_term   [SLOTS];
  cst_pkg::cst_out_t expected_q[$];
  int unsigned       mismatches;

  function logic [15:0] id_bits(logic [15:0] v);
    if (ID_W >= 16) return v;
    return v & ((16'd1 << ID_W) - 16'd1);
  endfunction

  // predict the result of one accepted command and update the table copy
  function void note_command(cst_pkg::cst_in_t c);
    cst_pkg::cst_out_t res;
    bit                two;
    logic [15:0]       sym;
    logic [15:0]       first;
    logic [15:0]       second;
    int                hit;
    int                free_slot;
    res = '0;
    hit = -1;
    free_slot = -1;
    if (c.command == CMD_UNUSED) begin
      expected_q.push_back(res);
      return;
    end
    if (c.term_arity != cst_pkg::ARITY_ONE && c.term_arity != cst_pkg::ARITY_TWO) begin
      res.status = cst_pkg::ST_WRONG_ARITY;
      expected_q.push_back(res);
      return;
    end
    two    = (c.term_arity == cst_pkg::ARITY_TWO);
    sym    = id_bits(c.symbol_id);
    first  = id_bits(c.first_class);
    second = two ? id_bits(c.second_class) : 16'd0;
    for (int i = 0; i < SLOTS; i++) begin
      if (hit < 0 && slot_used[i] && slot_two[i] == two && slot_sym[i] == sym &&
          slot_first[i] == first && slot_second[i] == second) begin
        hit = i;
      end
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    case (c.command)
      cst_pkg::CMD_ENTER: begin
        if (hit < 0) begin
          if (free_slot < 0) begin
            res.status = cst_pkg::ST_FULL;
          end else begin
            slot_used[free_slot]   = 1'b1;
            slot_two[free_slot]    = two;
            slot_sym[free_slot]    = sym;
            slot_first[free_slot]  = first;
            slot_second[free_slot] = second;
            slot_term[free_slot]   = c.term_ref;
          end
        end
      end
      cst_pkg::CMD_REMOVE: begin
        if (hit < 0) res.status = cst_pkg::ST_NOT_FOUND;
        else slot_used[hit] = 1'b0;
      end
      default: begin
        if (hit < 0) res.status = cst_pkg::ST_NOT_FOUND;
        else res.found_term = slot_term[hit];
      end
    endcase
    expected_q.push_back(res);
  endfunction

  function void check_result(cst_pkg::cst_out_t got);
    cst_pkg::cst_out_t want;
    if (expected_q.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("unexpected result: status %0d term %h", got.status, got.found_term);
      end
      return;
    end
    want = expected_q.pop_front();
    if (got.status !== want.status || got.found_term !== want.found_term) begin
      mismatches++;
      if (mismatches <= 10) begin
        $display("result mismatch: expected status %0d term %h, got status %0d term %h",
                 want.status, want.found_term, got.status, got.found_term);
      end
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import cst_pkg::*;

  localparam int unsigned SLOTS        = TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_ITEMS = 2000;
  localparam int unsigned MAX_GAP      = 20;
  localparam int unsigned MAX_STALL    = 40;
  localparam int unsigned CYCLE_LIMIT  =
    4 * (RANDOM_ITEMS + 100) * (SLOTS + 3 + MAX_GAP + MAX_STALL) + 4 * SLOTS;

  logic clk_i;
  logic rst_ni;

  cst_stream_if #(.payload_t(cst_in_t))  in_if ();
  cst_stream_if #(.payload_t(cst_out_t)) out_if ();

  congruence_signature_table_top dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sig_table_scoreboard table_sb;
  int unsigned         cycle_count = 0;
  bit                  rx_stalls_on;
  int unsigned         stall_left;
  cst_in_t             recent_keys[$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // receiver stall pattern
  always @(posedge clk_i) begin
    if (stall_left != 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= stall_left - 1;
    end else if (rx_stalls_on && $urandom_range(0, 7) == 0) begin
      out_if.ready <= 1'b0;
      stall_left   <= $urandom_range(0, MAX_STALL - 1);
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) table_sb.check_result(out_if.payload);
  end

  function automatic cst_in_t make_cmd(logic [1:0] cmd, logic [2:0] arity, logic [15:0] sym,
                                       logic [15:0] first, logic [15:0] second,
                                       logic [15:0] term);
    cst_in_t c;
    c.command      = cmd;
    c.term_arity   = arity;
    c.symbol_id    = sym;
    c.first_class  = first;
    c.second_class = second;
    c.term_ref     = term;
    return c;
  endfunction

  // mostly a small pool so that keys collide, sometimes the full range
  function automatic logic [15:0] pick_id();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom);
      1:       return $urandom_range(0, 1) ? 16'hffff : 16'h0000;
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  function automatic cst_in_t random_command(int unsigned enter_pct, int unsigned remove_pct);
    cst_in_t     c;
    cst_in_t     old;
    int unsigned roll;
    int unsigned reuse_pct;
    roll = $urandom_range(0, 99);
    c = '0;
    if (roll < 3) c.command = CMD_UNUSED;
    else if (roll < 3 + enter_pct) c.command = CMD_ENTER;
    else if (roll < 3 + enter_pct + remove_pct) c.command = CMD_REMOVE;
    else c.command = CMD_QUERY;
    reuse_pct = (c.command == CMD_ENTER) ? 25 : 65;
    if (recent_keys.size() != 0 && $urandom_range(0, 99) < reuse_pct) begin
      old = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      c.term_arity   = old.term_arity;
      c.symbol_id    = old.symbol_id;
      c.first_class  = old.first_class;
      c.second_class = (old.term_arity == ARITY_ONE) ? 16'($urandom) : old.second_class;
    end else begin
      c.term_arity   = ($urandom_range(0, 9) != 0) ? 3'($urandom_range(1, 2))
                                                   : 3'($urandom_range(0, 7));
      c.symbol_id    = pick_id();
      c.first_class  = pick_id();
      c.second_class = pick_id();
    end
    c.term_ref = 16'($urandom);
    return c;
  endfunction

  task automatic send_command(cst_in_t c);
    in_if.valid   <= 1'b1;
    in_if.payload <= c;
    do @(posedge clk_i); while (!in_if.ready);
    table_sb.note_command(c);
    if (c.command == CMD_ENTER && (c.term_arity == ARITY_ONE || c.term_arity == ARITY_TWO))
    begin
      recent_keys.push_back(c);
      if (recent_keys.size() > 96) void'(recent_keys.pop_front());
    end
  endtask

  task automatic idle_cycles(int unsigned n);
    if (n == 0) return;
    in_if.valid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic run_directed();
    send_command(make_cmd(CMD_QUERY,  ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_REMOVE, ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_ENTER,  ARITY_ONE, 16'h0000, 16'h0000, 16'hffff, 16'hffff));
    // same key again, second class ignored for arity one
    send_command(make_cmd(CMD_ENTER,  ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h1234));
    send_command(make_cmd(CMD_QUERY,  ARITY_ONE, 16'h0000, 16'h0000, 16'h5555, 16'hffff));
    send_command(make_cmd(CMD_ENTER,  ARITY_TWO, 16'h0000, 16'h0000, 16'h0000, 16'h0001));
    send_command(make_cmd(CMD_QUERY,  ARITY_TWO, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_ENTER,  ARITY_TWO, 16'hffff, 16'hffff, 16'hffff, 16'h0000));
    send_command(make_cmd(CMD_QUERY,  ARITY_TWO, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_command(make_cmd(CMD_QUERY,  ARITY_TWO, 16'hffff, 16'hffff, 16'hfffe, 16'h0000));
    // unsupported arities
    send_command(make_cmd(CMD_ENTER,  3'd0, 16'h0000, 16'h0000, 16'h0000, 16'hffff));
    send_command(make_cmd(CMD_REMOVE, 3'd3, 16'hffff, 16'hffff, 16'hffff, 16'h0000));
    send_command(make_cmd(CMD_QUERY,  3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_command(make_cmd(CMD_ENTER,  3'd4, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_UNUSED, ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'hffff));
    send_command(make_cmd(CMD_UNUSED, 3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff));
    send_command(make_cmd(CMD_REMOVE, ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_QUERY,  ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_REMOVE, ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
    send_command(make_cmd(CMD_ENTER,  ARITY_ONE, 16'h0000, 16'h0000, 16'h0000, 16'haaaa));
    send_command(make_cmd(CMD_QUERY,  ARITY_ONE, 16'h0000, 16'h0000, 16'hffff, 16'h0000));
    send_command(make_cmd(CMD_QUERY,  ARITY_TWO, 16'h0000, 16'h0000, 16'h0000, 16'h0000));
  endtask

  initial begin
    int unsigned sent;
    int unsigned taken;
    int unsigned phase_len;
    int unsigned burst_left;
    int unsigned enter_pct;
    int unsigned remove_pct;
    bit          tx_gaps;
    table_sb       = new();
    sent           = 0;
    burst_left     = 0;
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.payload  = '0;
    out_if.ready   = 1'b0;
    rx_stalls_on   = 1'b0;
    stall_left     = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    run_directed();

    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 2))
        0: begin enter_pct = 75; remove_pct = 10; end
        1: begin enter_pct = 10; remove_pct = 60; end
        default: begin enter_pct = 35; remove_pct = 30; end
      endcase
      tx_gaps      = ($urandom_range(0, 3) != 0);
      rx_stalls_on <= ($urandom_range(0, 3) != 0);
      phase_len    = $urandom_range(60, 250);
      taken        = 0;
      while (taken < phase_len && sent < RANDOM_ITEMS) begin
        send_command(random_command(enter_pct, remove_pct));
        taken++;
        sent++;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          if (tx_gaps) idle_cycles($urandom_range(1, MAX_GAP));
        end else begin
          burst_left--;
        end
      end
    end

    in_if.valid <= 1'b0;
    while (table_sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (SLOTS + 8) @(posedge clk_i);
    if (table_sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end
endmodule
